/* hdl/bgrm_pkg.sv */
`timescale 1ns / 1ps

package bgrm_pkg;

    // Field widths fixed by the reading format.
    localparam int VOLT_W     = 12;
    localparam int CHG_W      = 16;
    localparam int RAW_W      = 16;
    localparam int CNT_W      = 8;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_READ_ERR = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_WORD = 2'd2;
    localparam logic [STATUS_W-1:0] ST_HIGH     = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_MIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_MAX     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_STEP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_STEP  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PERSIST_LIM  = 3'd7;

    // Raw voltage words that never come from a working gauge.
    localparam logic [RAW_W-1:0] RAW_ALL_ZERO = 16'h0000;
    localparam logic [RAW_W-1:0] RAW_ALL_ONE  = 16'hFFFF;

    // Configuration values after reset.
    localparam logic [VOLT_W-1:0] RST_VOLT_MIN    = 12'd2400;
    localparam logic [VOLT_W-1:0] RST_VOLT_MAX    = 12'd3440;
    localparam logic [CHG_W-1:0]  RST_CHARGE_MIN  = 16'd0;
    localparam logic [CHG_W-1:0]  RST_CHARGE_MAX  = 16'd25600;
    localparam logic [VOLT_W-1:0] RST_VOLT_STEP   = 12'd8;
    localparam logic [CHG_W-1:0]  RST_CHARGE_STEP = 16'd128;
    localparam logic [CNT_W-1:0]  RST_ERROR_LIMIT = 8'd5;
    localparam logic [CNT_W-1:0]  RST_PERSIST_LIM = 8'd10;

    typedef struct packed {
        logic [VOLT_W-1:0] volt_min;
        logic [VOLT_W-1:0] volt_max;
        logic [CHG_W-1:0]  charge_min;
        logic [CHG_W-1:0]  charge_max;
        logic [VOLT_W-1:0] volt_step;
        logic [CHG_W-1:0]  charge_step;
        logic [CNT_W-1:0]  error_limit;
        logic [CNT_W-1:0]  persist_limit;
    } cfg_t;

    // A classified reading, as it travels from the front to the back.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VOLT_W-1:0]   code;
        logic [CHG_W-1:0]    charge;
        logic                present;
        logic                alert_ok;
        logic                alert_bit;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VOLT_W-1:0]   voltage_code;
        logic [CHG_W-1:0]    charge_level;
        logic                cell_present;
        logic                alert_active;
        logic                change_report;
        logic                first_alert;
        logic                alert_persistent;
        logic                clear_alert_request;
        logic                sensor_reset_request;
    } result_t;

endpackage

/* hdl/bgrm_front.sv */
`timescale 1ns / 1ps

module bgrm_front
    import bgrm_pkg::*;
(
    input  logic             reads_ok,
    input  logic [RAW_W-1:0] vcell_raw,
    input  logic [CHG_W-1:0] charge_raw,
    input  logic             alert_read_ok,
    input  logic             alert_bit,
    input  cfg_t             cfg,
    output item_t            item
);

    logic [VOLT_W-1:0] code;
    logic              below_min;
    logic              above_max;
    logic              present;
    logic [CHG_W-1:0]  clamped;

    // The voltage code sits in the upper twelve bits of the raw word.
    assign code      = vcell_raw[RAW_W-1:RAW_W-VOLT_W];
    assign below_min = code < cfg.volt_min;
    assign above_max = code > cfg.volt_max;
    assign present   = !below_min && !above_max;

    // Clamp the charge to its limits.
    always_comb
    begin
        if (charge_raw < cfg.charge_min)
        begin
            clamped = cfg.charge_min;
        end
        else if (charge_raw > cfg.charge_max)
        begin
            clamped = cfg.charge_max;
        end
        else
        begin
            clamped = charge_raw;
        end
    end

    // Classify the reading and build the item for the back end.
    always_comb
    begin
        item.code      = code;
        item.present   = present;
        item.alert_ok  = alert_read_ok;
        item.alert_bit = alert_bit;
        item.charge    = below_min ? '0 : clamped;
        if (!reads_ok)
        begin
            item.status = ST_READ_ERR;
        end
        else if (vcell_raw == RAW_ALL_ZERO || vcell_raw == RAW_ALL_ONE)
        begin
            item.status = ST_BAD_WORD;
        end
        else if (present || below_min)
        begin
            item.status = ST_OK;
        end
        else
        begin
            item.status = ST_HIGH;
        end
    end

endmodule

/* hdl/bgrm_queue.sv */
`timescale 1ns / 1ps

module bgrm_queue
    import bgrm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  enq,
    input  item_t enq_item,
    output logic  full,
    input  logic  deq,
    output logic  head_valid,
    output item_t head_item
);

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_enq;
    logic       do_deq;

    assign full       = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head_item  = entry_reg[rd_ptr_reg];
    assign do_enq     = enq && !full;
    assign do_deq     = deq && head_valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_enq ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_deq ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_enq && !do_deq)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_deq && !do_enq)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_enq)
        begin
            entry_reg[wr_ptr_reg] <= enq_item;
        end
    end

endmodule

/* hdl/bgrm_back.sv */
`timescale 1ns / 1ps

module bgrm_back
    import bgrm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    head_valid,
    input  item_t   head_item,
    output logic    deq,
    input  logic    pop,
    output logic    empty,
    output result_t rslt
);

    // Monitor state.
    logic [VOLT_W-1:0] stored_voltage_reg;
    logic [VOLT_W-1:0] stored_voltage_next;
    logic [CHG_W-1:0]  stored_charge_reg;
    logic [CHG_W-1:0]  stored_charge_next;
    logic              stored_alert_reg;
    logic              stored_alert_next;
    logic              stored_present_reg;
    logic              stored_present_next;
    logic [CNT_W-1:0]  error_run_reg;
    logic [CNT_W-1:0]  error_run_next;
    logic [CNT_W-1:0]  alert_ticks_reg;
    logic [CNT_W-1:0]  alert_ticks_next;
    logic [VOLT_W-1:0] reported_voltage_reg;
    logic [VOLT_W-1:0] reported_voltage_next;
    logic [CHG_W-1:0]  reported_charge_reg;
    logic [CHG_W-1:0]  reported_charge_next;
    logic              reported_valid_reg;
    logic              reported_valid_next;

    // Result queue.
    result_t    res_entry_reg [2];
    logic       res_wr_ptr_reg;
    logic       res_wr_ptr_next;
    logic       res_rd_ptr_reg;
    logic       res_rd_ptr_next;
    logic [1:0] res_count_reg;
    logic [1:0] res_count_next;

    logic              do_pop;
    logic              res_room;
    logic [VOLT_W-1:0] volt_diff;
    logic [CHG_W-1:0]  charge_diff;
    logic [CNT_W-1:0]  error_inc;
    result_t           res;

    assign empty    = res_count_reg == 2'd0;
    assign rslt     = res_entry_reg[res_rd_ptr_reg];
    assign do_pop   = pop && !empty;
    assign res_room = (res_count_reg != 2'd2) || do_pop;
    assign deq      = head_valid && res_room;

    // Distances from the last reported values; only used on good ticks, where the
    // new stored values are the item's own.
    assign volt_diff   = (head_item.code > reported_voltage_reg) ?
                         head_item.code - reported_voltage_reg :
                         reported_voltage_reg - head_item.code;
    assign charge_diff = (head_item.charge > reported_charge_reg) ?
                         head_item.charge - reported_charge_reg :
                         reported_charge_reg - head_item.charge;
    assign error_inc   = error_run_reg + 8'd1;

    // State update and result for the item at the head of the queue.
    always_comb
    begin
        stored_voltage_next   = stored_voltage_reg;
        stored_charge_next    = stored_charge_reg;
        stored_alert_next     = stored_alert_reg;
        stored_present_next   = stored_present_reg;
        error_run_next        = error_run_reg;
        alert_ticks_next      = alert_ticks_reg;
        reported_voltage_next = reported_voltage_reg;
        reported_charge_next  = reported_charge_reg;
        reported_valid_next   = reported_valid_reg;
        res                   = '0;
        if (deq)
        begin
            // An accepted word updates the stored readings, even when it is above range.
            if (head_item.status == ST_OK || head_item.status == ST_HIGH)
            begin
                stored_voltage_next = head_item.code;
                stored_charge_next  = head_item.charge;
                stored_present_next = head_item.present;
                if (head_item.alert_ok)
                begin
                    stored_alert_next = head_item.alert_bit;
                end
            end
            // The alert is reported as read, before any clear.
            res.alert_active    = stored_alert_next;
            res.status          = head_item.status;
            res.voltage_code    = stored_voltage_next;
            res.charge_level    = stored_charge_next;
            res.cell_present    = stored_present_next;
            if (head_item.status == ST_OK)
            begin
                error_run_next = '0;
                if (!reported_valid_reg || volt_diff > cfg.volt_step ||
                    charge_diff > cfg.charge_step)
                begin
                    res.change_report     = 1'b1;
                    reported_voltage_next = head_item.code;
                    reported_charge_next  = head_item.charge;
                    reported_valid_next   = 1'b1;
                end
                if (stored_alert_next && stored_present_next)
                begin
                    alert_ticks_next = (alert_ticks_reg != '1) ?
                                       alert_ticks_reg + 8'd1 : alert_ticks_reg;
                    res.first_alert      = alert_ticks_next == 8'd1;
                    res.alert_persistent = (alert_ticks_next != 8'd1) &&
                                           (alert_ticks_next > cfg.persist_limit);
                    res.clear_alert_request = 1'b1;
                    stored_alert_next       = 1'b0;
                end
                else
                begin
                    alert_ticks_next = '0;
                end
            end
            else
            begin
                // Count the failed tick and ask for a sensor reset at the limit.
                if (error_inc >= cfg.error_limit)
                begin
                    res.sensor_reset_request = 1'b1;
                    error_run_next           = '0;
                end
                else
                begin
                    error_run_next = error_inc;
                end
            end
        end
    end

    // Result queue pointers and fill count.
    always_comb
    begin
        res_wr_ptr_next = deq ? !res_wr_ptr_reg : res_wr_ptr_reg;
        res_rd_ptr_next = do_pop ? !res_rd_ptr_reg : res_rd_ptr_reg;
        res_count_next  = res_count_reg;
        if (deq && !do_pop)
        begin
            res_count_next = res_count_reg + 2'd1;
        end
        else if (do_pop && !deq)
        begin
            res_count_next = res_count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_voltage_reg   <= '0;
            stored_charge_reg    <= '0;
            stored_alert_reg     <= 1'b0;
            stored_present_reg   <= 1'b0;
            error_run_reg        <= '0;
            alert_ticks_reg      <= '0;
            reported_voltage_reg <= '0;
            reported_charge_reg  <= '0;
            reported_valid_reg   <= 1'b0;
            res_wr_ptr_reg       <= 1'b0;
            res_rd_ptr_reg       <= 1'b0;
            res_count_reg        <= 2'd0;
        end
        else
        begin
            stored_voltage_reg   <= stored_voltage_next;
            stored_charge_reg    <= stored_charge_next;
            stored_alert_reg     <= stored_alert_next;
            stored_present_reg   <= stored_present_next;
            error_run_reg        <= error_run_next;
            alert_ticks_reg      <= alert_ticks_next;
            reported_voltage_reg <= reported_voltage_next;
            reported_charge_reg  <= reported_charge_next;
            reported_valid_reg   <= reported_valid_next;
            res_wr_ptr_reg       <= res_wr_ptr_next;
            res_rd_ptr_reg       <= res_rd_ptr_next;
            res_count_reg        <= res_count_next;
        end
    end

    // Result storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (deq)
        begin
            res_entry_reg[res_wr_ptr_reg] <= res;
        end
    end

endmodule

/* hdl/battery_gauge_reading_monitor_core.sv */
`timescale 1ns / 1ps
// Battery gauge reading monitor.
// Input channel: one beat per once-a-second gauge reading (reads_ok, vcell_raw,
// charge_raw, alert_read_ok, alert_bit). A beat is taken on a clock edge with
// push high and full low.
// Result channel: one beat per reading, in order. While empty is low the oldest
// result is on the result ports; it is taken on an edge with pop high.
// Configuration: cfg_we writes cfg_wdata (low bits) into register cfg_index at
// the clock edge; write only while no reading is in flight.
// A reading accepted into the input queue goes through the back into the result
// queue. Throughput: one reading per cycle, sustained while results are popped.
// The front classifies in the cycle of acceptance, a two-entry queue holds
// classified readings, and the back updates the monitor state and fills a
// two-entry result queue. If the receiver stalls, both queues fill and full
// rises after at most four readings; nothing is dropped.
// Reset clears all monitor state and loads the default limits; both queues are
// empty and full is low.

module battery_gauge_reading_monitor_core
    import bgrm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input channel
    input  logic                  push,
    output logic                  full,
    input  logic                  reads_ok,
    input  logic [RAW_W-1:0]      vcell_raw,
    input  logic [CHG_W-1:0]      charge_raw,
    input  logic                  alert_read_ok,
    input  logic                  alert_bit,
    // Result channel
    output logic                  empty,
    input  logic                  pop,
    output logic [STATUS_W-1:0]   status,
    output logic [VOLT_W-1:0]     voltage_code,
    output logic [CHG_W-1:0]      charge_level,
    output logic                  cell_present,
    output logic                  alert_active,
    output logic                  change_report,
    output logic                  first_alert,
    output logic                  alert_persistent,
    output logic                  clear_alert_request,
    output logic                  sensor_reset_request,
    // Configuration port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t    cfg_reg;
    item_t   front_item;
    item_t   head_item;
    logic    head_valid;
    logic    deq;
    result_t rslt;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.volt_min      <= RST_VOLT_MIN;
            cfg_reg.volt_max      <= RST_VOLT_MAX;
            cfg_reg.charge_min    <= RST_CHARGE_MIN;
            cfg_reg.charge_max    <= RST_CHARGE_MAX;
            cfg_reg.volt_step     <= RST_VOLT_STEP;
            cfg_reg.charge_step   <= RST_CHARGE_STEP;
            cfg_reg.error_limit   <= RST_ERROR_LIMIT;
            cfg_reg.persist_limit <= RST_PERSIST_LIM;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_VOLT_MIN:    cfg_reg.volt_min      <= cfg_wdata[VOLT_W-1:0];
                CFG_VOLT_MAX:    cfg_reg.volt_max      <= cfg_wdata[VOLT_W-1:0];
                CFG_CHARGE_MIN:  cfg_reg.charge_min    <= cfg_wdata[CHG_W-1:0];
                CFG_CHARGE_MAX:  cfg_reg.charge_max    <= cfg_wdata[CHG_W-1:0];
                CFG_VOLT_STEP:   cfg_reg.volt_step     <= cfg_wdata[VOLT_W-1:0];
                CFG_CHARGE_STEP: cfg_reg.charge_step   <= cfg_wdata[CHG_W-1:0];
                CFG_ERROR_LIMIT: cfg_reg.error_limit   <= cfg_wdata[CNT_W-1:0];
                CFG_PERSIST_LIM: cfg_reg.persist_limit <= cfg_wdata[CNT_W-1:0];
                default:         cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // Front: classify the incoming reading.
    bgrm_front u_front (
        .reads_ok      (reads_ok),
        .vcell_raw     (vcell_raw),
        .charge_raw    (charge_raw),
        .alert_read_ok (alert_read_ok),
        .alert_bit     (alert_bit),
        .cfg           (cfg_reg),
        .item          (front_item)
    );

    // Queue between front and back.
    bgrm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .enq        (push),
        .enq_item   (front_item),
        .full       (full),
        .deq        (deq),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // Back: monitor state and result queue.
    bgrm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .deq        (deq),
        .pop        (pop),
        .empty      (empty),
        .rslt       (rslt)
    );

    assign status               = rslt.status;
    assign voltage_code         = rslt.voltage_code;
    assign charge_level         = rslt.charge_level;
    assign cell_present         = rslt.cell_present;
    assign alert_active         = rslt.alert_active;
    assign change_report        = rslt.change_report;
    assign first_alert          = rslt.first_alert;
    assign alert_persistent     = rslt.alert_persistent;
    assign clear_alert_request  = rslt.clear_alert_request;
    assign sensor_reset_request = rslt.sensor_reset_request;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import bgrm_pkg::*;

    localparam int CYCLE_LIMIT = 100000;

    // One gauge reading as offered on the input side.
    typedef struct {
        logic             reads_ok;
        logic [RAW_W-1:0] vcell_raw;
        logic [CHG_W-1:0] charge_raw;
        logic             alert_read_ok;
        logic             alert_bit;
    } gauge_reading_t;

    // Tick predictor and the store of results still to arrive.
    class tick_scoreboard;
        cfg_t              cfg;
        logic [VOLT_W-1:0] volt_q;
        logic [CHG_W-1:0]  charge_q;
        logic              alert_q;
        logic              present_q;
        logic [CNT_W-1:0]  err_run;
        logic [CNT_W-1:0]  alert_ticks;
        logic [VOLT_W-1:0] rep_volt;
        logic [CHG_W-1:0]  rep_charge;
        logic              rep_valid;
        result_t           expected_results[$];
        int                mismatches;
        int                checked;
        int                noted;
        int                resets_seen;
        int                firsts_seen;
        int                persists_seen;
        int                changes_seen;

        function new();
            cfg.volt_min      = RST_VOLT_MIN;
            cfg.volt_max      = RST_VOLT_MAX;
            cfg.charge_min    = RST_CHARGE_MIN;
            cfg.charge_max    = RST_CHARGE_MAX;
            cfg.volt_step     = RST_VOLT_STEP;
            cfg.charge_step   = RST_CHARGE_STEP;
            cfg.error_limit   = RST_ERROR_LIMIT;
            cfg.persist_limit = RST_PERSIST_LIM;
            volt_q      = '0;
            charge_q    = '0;
            alert_q     = 1'b0;
            present_q   = 1'b0;
            err_run     = '0;
            alert_ticks = '0;
            rep_volt    = '0;
            rep_charge  = '0;
            rep_valid   = 1'b0;
            mismatches  = 0;
            checked     = 0;
            noted       = 0;
            resets_seen   = 0;
            firsts_seen   = 0;
            persists_seen = 0;
            changes_seen  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_VOLT_MIN:    cfg.volt_min      = data[VOLT_W-1:0];
                CFG_VOLT_MAX:    cfg.volt_max      = data[VOLT_W-1:0];
                CFG_CHARGE_MIN:  cfg.charge_min    = data[CHG_W-1:0];
                CFG_CHARGE_MAX:  cfg.charge_max    = data[CHG_W-1:0];
                CFG_VOLT_STEP:   cfg.volt_step     = data[VOLT_W-1:0];
                CFG_CHARGE_STEP: cfg.charge_step   = data[CHG_W-1:0];
                CFG_ERROR_LIMIT: cfg.error_limit   = data[CNT_W-1:0];
                CFG_PERSIST_LIM: cfg.persist_limit = data[CNT_W-1:0];
                default:         ;
            endcase
        endfunction

        function int unsigned distance(int unsigned a, int unsigned b);
            return (a > b) ? a - b : b - a;
        endfunction

        // Works out the result of one tick and advances the monitor state.
        function result_t evaluate_tick(gauge_reading_t r);
            result_t             res;
            logic [VOLT_W-1:0]   code;
            logic [CHG_W-1:0]    chg;
            logic [STATUS_W-1:0] st;
            res = '0;
            st  = ST_OK;
            if (!r.reads_ok)
            begin
                st = ST_READ_ERR;
            end
            else if (r.vcell_raw == RAW_ALL_ZERO || r.vcell_raw == RAW_ALL_ONE)
            begin
                st = ST_BAD_WORD;
            end
            else
            begin
                code = r.vcell_raw[RAW_W-1:RAW_W-VOLT_W];
                chg  = r.charge_raw;
                if (!(chg >= cfg.charge_min && chg <= cfg.charge_max))
                    chg = (chg < cfg.charge_min) ? cfg.charge_min : cfg.charge_max;
                if (r.alert_read_ok)
                    alert_q = r.alert_bit;
                volt_q    = code;
                present_q = (code >= cfg.volt_min && code <= cfg.volt_max);
                if (!present_q)
                begin
                    if (code < cfg.volt_min)
                        chg = '0;
                    else if (code > cfg.volt_max)
                        st = ST_HIGH;
                end
                charge_q = chg;
            end
            res.alert_active = alert_q;

            if (st == ST_OK)
            begin
                err_run = '0;
                if (!rep_valid || distance(volt_q, rep_volt) > cfg.volt_step ||
                    distance(charge_q, rep_charge) > cfg.charge_step)
                begin
                    res.change_report = 1'b1;
                    rep_volt   = volt_q;
                    rep_charge = charge_q;
                    rep_valid  = 1'b1;
                end
                if (alert_q && present_q)
                begin
                    if (alert_ticks != 8'hFF)
                        alert_ticks = alert_ticks + 8'd1;
                    if (alert_ticks == 8'd1)
                        res.first_alert = 1'b1;
                    else if (alert_ticks > cfg.persist_limit)
                        res.alert_persistent = 1'b1;
                    res.clear_alert_request = 1'b1;
                    alert_q = 1'b0;
                end
                else
                begin
                    alert_ticks = '0;
                end
            end
            else
            begin
                err_run = err_run + 8'd1;
                if (err_run >= cfg.error_limit)
                begin
                    res.sensor_reset_request = 1'b1;
                    err_run = '0;
                end
            end

            res.status          = st;
            res.voltage_code    = volt_q;
            res.charge_level    = charge_q;
            res.cell_present    = present_q;
            return res;
        endfunction

        function void note_reading(gauge_reading_t r);
            result_t res;
            res = evaluate_tick(r);
            expected_results.push_back(res);
            noted++;
            resets_seen   += res.sensor_reset_request;
            firsts_seen   += res.first_alert;
            persists_seen += res.alert_persistent;
            changes_seen  += res.change_report;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            mismatches++;
        endtask

        task compare(string name, int unsigned got, int unsigned want);
            if (got != want)
                report($sformatf("result %0d: %s is %0h, %0h expected", checked, name,
                                 got, want));
        endtask

        task check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0)
            begin
                report("result beat with no reading waiting");
            end
            else
            begin
                want = expected_results.pop_front();
                compare("status", got.status, want.status);
                compare("voltage_code", got.voltage_code, want.voltage_code);
                compare("charge_level", got.charge_level, want.charge_level);
                compare("cell_present", got.cell_present, want.cell_present);
                compare("alert_active", got.alert_active, want.alert_active);
                compare("change_report", got.change_report, want.change_report);
                compare("first_alert", got.first_alert, want.first_alert);
                compare("alert_persistent", got.alert_persistent, want.alert_persistent);
                compare("clear_alert_request", got.clear_alert_request,
                        want.clear_alert_request);
                compare("sensor_reset_request", got.sensor_reset_request,
                        want.sensor_reset_request);
            end
            checked++;
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    logic                  reads_ok;
    logic [RAW_W-1:0]      vcell_raw;
    logic [CHG_W-1:0]      charge_raw;
    logic                  alert_read_ok;
    logic                  alert_bit;
    logic                  empty;
    logic                  pop;
    logic [STATUS_W-1:0]   status;
    logic [VOLT_W-1:0]     voltage_code;
    logic [CHG_W-1:0]      charge_level;
    logic                  cell_present;
    logic                  alert_active;
    logic                  change_report;
    logic                  first_alert;
    logic                  alert_persistent;
    logic                  clear_alert_request;
    logic                  sensor_reset_request;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    tick_scoreboard sb;
    int             burst_left;
    int             alert_pct;
    int             settings_applied;
    int             cycles;

    battery_gauge_reading_monitor_core dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .push                 (push),
        .full                 (full),
        .reads_ok             (reads_ok),
        .vcell_raw            (vcell_raw),
        .charge_raw           (charge_raw),
        .alert_read_ok        (alert_read_ok),
        .alert_bit            (alert_bit),
        .empty                (empty),
        .pop                  (pop),
        .status               (status),
        .voltage_code         (voltage_code),
        .charge_level         (charge_level),
        .cell_present         (cell_present),
        .alert_active         (alert_active),
        .change_report        (change_report),
        .first_alert          (first_alert),
        .alert_persistent     (alert_persistent),
        .clear_alert_request  (clear_alert_request),
        .sensor_reset_request (sensor_reset_request),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit in case the block locks up.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding", cycles,
                 sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic gauge_reading_t mk(logic ok, logic [RAW_W-1:0] v,
                                          logic [CHG_W-1:0] c, logic aok, logic ab);
        gauge_reading_t r;
        r.reads_ok      = ok;
        r.vcell_raw     = v;
        r.charge_raw    = c;
        r.alert_read_ok = aok;
        r.alert_bit     = ab;
        return r;
    endfunction

    function automatic int jitter(int spread);
        return int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    function automatic int clamp(int v, int hi);
        if (v < 0)
            return 0;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Voltage codes cluster around the limits and around the last stored code.
    function automatic logic [VOLT_W-1:0] pick_code();
        int c;
        int lo;
        int hi;
        lo = int'(sb.cfg.volt_min);
        hi = int'(sb.cfg.volt_max);
        case ($urandom_range(0, 4))
            0: c = lo + jitter(3);
            1: c = hi + jitter(3);
            2: c = int'($urandom_range(0, 4095));
            3: c = int'(sb.volt_q) + jitter(int'(sb.cfg.volt_step) + 2);
            default:
                c = (lo <= hi) ? lo + int'($urandom_range(0, hi - lo))
                               : int'($urandom_range(0, 4095));
        endcase
        return VOLT_W'(clamp(c, 4095));
    endfunction

    // Charge values cluster around the limits and around the last reported charge.
    function automatic logic [CHG_W-1:0] pick_charge();
        int c;
        int lo;
        int hi;
        lo = int'(sb.cfg.charge_min);
        hi = int'(sb.cfg.charge_max);
        case ($urandom_range(0, 4))
            0: c = lo + jitter(3);
            1: c = hi + jitter(3);
            2: c = int'($urandom_range(0, 65535));
            3: c = int'(sb.rep_charge) + jitter(int'(sb.cfg.charge_step) + 2);
            default:
                c = (lo <= hi) ? lo + int'($urandom_range(0, hi - lo))
                               : int'($urandom_range(0, 65535));
        endcase
        return CHG_W'(clamp(c, 65535));
    endfunction

    // Mostly well-formed readings, with read failures, bad words and noise mixed in.
    function automatic gauge_reading_t random_reading();
        gauge_reading_t r;
        int             k;
        k = int'($urandom_range(0, 99));
        r.reads_ok      = 1'b1;
        r.vcell_raw     = {pick_code(), 4'($urandom)};
        r.charge_raw    = pick_charge();
        r.alert_read_ok = ($urandom_range(0, 9) != 0);
        r.alert_bit     = (int'($urandom_range(0, 99)) < alert_pct);
        if (k >= 72 && k < 82)
        begin
            r.reads_ok  = 1'b0;
            r.vcell_raw = 16'($urandom);
        end
        else if (k >= 82 && k < 87)
        begin
            r.vcell_raw = ($urandom_range(0, 1) != 0) ? RAW_ALL_ONE : RAW_ALL_ZERO;
        end
        else if (k >= 87)
        begin
            r = mk(1'($urandom), 16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
        end
        return r;
    endfunction

    // Offers one beat and holds it until the block takes it.
    task automatic send(gauge_reading_t r);
        @(negedge clk);
        push          <= 1'b1;
        reads_ok      <= r.reads_ok;
        vcell_raw     <= r.vcell_raw;
        charge_raw    <= r.charge_raw;
        alert_read_ok <= r.alert_read_ok;
        alert_bit     <= r.alert_bit;
        do
            @(posedge clk);
        while (full);
        sb.note_reading(r);
    endtask

    task automatic idle(int n);
        @(negedge clk);
        push <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Bursts of random length separated by random gaps, sometimes none at all.
    task automatic pace();
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            if ($urandom_range(0, 3) != 0)
                idle(int'($urandom_range(1, 8)));
            burst_left = int'($urandom_range(1, 24));
        end
    endtask

    // Waits until every expected result has been taken.
    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        sb.set_reg(idx, CFG_DATA_W'(val));
    endtask

    task automatic apply_setting(int unsigned vmin, int unsigned vmax, int unsigned cmin,
                                 int unsigned cmax, int unsigned vstep, int unsigned cstep,
                                 int unsigned elim, int unsigned plim);
        write_reg(CFG_VOLT_MIN, vmin);
        write_reg(CFG_VOLT_MAX, vmax);
        write_reg(CFG_CHARGE_MIN, cmin);
        write_reg(CFG_CHARGE_MAX, cmax);
        write_reg(CFG_VOLT_STEP, vstep);
        write_reg(CFG_CHARGE_STEP, cstep);
        write_reg(CFG_ERROR_LIMIT, elim);
        write_reg(CFG_PERSIST_LIM, plim);
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
        begin
            send(random_reading());
            pace();
        end
    endtask

    // A long unbroken alert run, so that the tick count saturates.
    task automatic alert_run(int n);
        gauge_reading_t r;
        for (int i = 0; i < n; i++)
        begin
            r = mk(1'b1, {12'($urandom_range(1, 4094)), 4'($urandom)}, 16'($urandom),
                   1'b1, 1'b1);
            if ($urandom_range(0, 29) == 0)
                r.reads_ok = 1'b0;
            send(r);
            pace();
        end
    endtask

    // Directed readings under the reset limits.
    task automatic directed_readings();
        // A read failure, both invalid words, an over-range code, then a fifth
        // error in a row, which asks for a sensor reset.
        send(mk(1'b0, 16'h1234, 16'h5678, 1'b1, 1'b1));
        send(mk(1'b1, RAW_ALL_ZERO, 16'h0000, 1'b1, 1'b0));
        send(mk(1'b1, RAW_ALL_ONE, 16'hFFFF, 1'b1, 1'b1));
        send(mk(1'b1, 16'hFFFE, 16'hFFFF, 1'b1, 1'b1));
        send(mk(1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0));
        // Lowest code: charge forced to zero, first change report.
        send(mk(1'b1, 16'h0001, 16'h0100, 1'b0, 1'b0));
        // Presence limits exactly, voltage step at and just over the threshold.
        send(mk(1'b1, {12'd2400, 4'hF}, 16'd25600, 1'b1, 1'b1));
        send(mk(1'b1, {12'd2408, 4'h0}, 16'd25600, 1'b1, 1'b1));
        send(mk(1'b1, {12'd2409, 4'h0}, 16'd25600, 1'b1, 1'b1));
        send(mk(1'b1, {12'd3440, 4'h0}, 16'd25601, 1'b1, 1'b1));
        // Charge step at and just over the threshold.
        send(mk(1'b1, {12'd3440, 4'h0}, 16'd25472, 1'b1, 1'b1));
        send(mk(1'b1, {12'd3440, 4'h0}, 16'd25471, 1'b1, 1'b1));
        // Keep the alert up until it becomes persistent.
        for (int i = 0; i < 5; i++)
        begin
            send(mk(1'b1, {12'd3000, 4'h5}, 16'd12800, 1'b1, 1'b1));
            pace();
        end
        // Alert not read this tick, so the count restarts.
        send(mk(1'b1, {12'd3000, 4'h5}, 16'd12800, 1'b0, 1'b1));
        // One code over and one code under the presence limits.
        send(mk(1'b1, {12'd3441, 4'h7}, 16'd100, 1'b1, 1'b0));
        send(mk(1'b1, {12'd2399, 4'h0}, 16'd100, 1'b1, 1'b1));
        send(mk(1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
        send(mk(1'b1, {12'd3000, 4'h0}, 16'd0, 1'b1, 1'b0));
    endtask

    // Receiver: stall pattern of its own, plus one long hold-off to fill the block.
    initial
    begin
        int          mode;
        int          mode_left;
        int          hold_left;
        bit          held_long;
        logic [7:0]  mask;
        logic        want;
        pop       = 1'b0;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        held_long = 1'b0;
        mask      = 8'hFF;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode      = int'($urandom_range(0, 3));
                mode_left = int'($urandom_range(10, 60));
                mask      = 8'($urandom);
            end
            mode_left--;
            case (mode)
                0:       want = 1'b1;
                1:       want = 1'($urandom);
                2:       want = ($urandom_range(0, 3) == 0);
                default:
                begin
                    want = mask[0];
                    mask = {mask[0], mask[7:1]};
                end
            endcase
            if (!held_long && sb.checked >= 300)
            begin
                hold_left = 150;
                held_long = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                want = 1'b0;
            end
            pop <= want;
        end
    end

    // Every result beat taken is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_result({status, voltage_code, charge_level, cell_present,
                             alert_active, change_report, first_alert, alert_persistent,
                             clear_alert_request, sensor_reset_request});
    end

    // Main sequence.
    initial
    begin
        sb               = new();
        burst_left       = 0;
        alert_pct        = 50;
        settings_applied = 0;
        rst_n            = 1'b0;
        push             = 1'b0;
        reads_ok         = 1'b0;
        vcell_raw        = '0;
        charge_raw       = '0;
        alert_read_ok    = 1'b0;
        alert_bit        = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_wdata        = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        directed_readings();
        drain();

        // Widest limits, zero steps, reset on every error, persistent from the second alert tick.
        apply_setting(0, 4095, 0, 65535, 0, 0, 1, 0);
        random_phase(100);
        drain();

        // Limits in the wrong order and the largest steps and counts.
        apply_setting(4095, 0, 65535, 0, 4095, 65535, 255, 255);
        random_phase(80);
        drain();

        // Typical limits with a raised charge floor and an error limit of zero.
        alert_pct = 85;
        apply_setting(2400, 3440, 1000, 20000, 8, 128, 0, 3);
        random_phase(150);
        drain();

        // Saturating alert count.
        apply_setting(0, 4095, 0, 65535, 8, 128, 5, 254);
        alert_run(262);
        drain();

        // Random limits.
        alert_pct = 60;
        apply_setting($urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 4095), $urandom_range(0, 65535),
                      $urandom_range(1, 255), $urandom_range(0, 255));
        random_phase(60);
        drain();
        repeat (8) @(posedge clk);

        $display("Run covered %0d readings and %0d checked results over %0d limit settings.",
                 sb.noted, sb.checked, settings_applied);
        $display("Seen: %0d change reports, %0d first alerts, %0d persistent, %0d resets.",
                 sb.changes_seen, sb.firsts_seen, sb.persists_seen, sb.resets_seen);
        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* battery_gauge_reading_monitor_core.f */
hdl/bgrm_pkg.sv
hdl/bgrm_front.sv
hdl/bgrm_queue.sv
hdl/bgrm_back.sv
hdl/battery_gauge_reading_monitor_core.sv
tb/tb.sv
